[src/dtlpd_pkg.sv]
// Package: types and constants shared by the length-prefix deframer modules.
`timescale 1ns / 1ps
package dtlpd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgAddrW-3:0] CfgIdxMinLen = 1'b0;

  localparam logic [15:0] MinLenReset = 16'd12;
  localparam logic [15:0] LenIdle     = 16'd2;

  typedef enum logic [3:0] {
    PH_LEN_HI = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_DEAD   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       end_of_chunk;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_message;
    logic        first_of_message;
    logic        last_of_message;
    logic [15:0] message_length;
    logic [15:0] message_id;
    logic        lost_sync;
    logic        stream_dead;
  } out_beat_t;

endpackage

[src/dtlpd_cfg.sv]
// Module: APB register bank holding the minimum message length.
`timescale 1ns / 1ps
module dtlpd_cfg import dtlpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [15:0]         min_len_o
);

  logic [15:0] min_len_q, min_len_d;
  logic        hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CfgAddrW-1:2] == CfgIdxMinLen);

  always_comb begin
    min_len_d = min_len_q;
    if (psel && penable && pwrite && hit) begin
      min_len_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else begin
      min_len_q <= min_len_d;
    end
  end

  assign prdata    = hit ? {{(CfgDataW-16){1'b0}}, min_len_q} : '0;
  assign min_len_o = min_len_q;

endmodule

[src/dtlpd_frame.sv]
// Module: framing state machine and per-byte result logic.
`timescale 1ns / 1ps
module dtlpd_frame import dtlpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_beat_t    beat_i,
  input  logic [15:0] min_len_i,
  output out_beat_t   res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] cur_len_q, cur_len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] id_q, id_d;
  logic [15:0] len_word, count_inc, id_next;
  out_beat_t   res;

  assign len_word  = {len_hi_q, beat_i.data_byte};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    len_hi_d  = len_hi_q;
    cur_len_d = cur_len_q;
    count_d   = count_q;
    id_d      = id_q;
    id_next   = id_q;
    res       = '0;
    if (beat_i.action) begin
      // restart: back to reset framing state
      phase_d   = PH_LEN_HI;
      len_hi_d  = 8'd0;
      cur_len_d = LenIdle;
      count_d   = 16'd0;
      id_d      = 16'd0;
    end else begin
      res.out_byte = beat_i.data_byte;
      unique case (phase_q)
        PH_LEN_HI: begin
          len_hi_d = beat_i.data_byte;
          count_d  = 16'd1;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          count_d = 16'd0;
          if (len_word == 16'd0) begin
            cur_len_d = LenIdle;
            phase_d   = PH_LEN_HI;
          end else if (len_word < min_len_i) begin
            cur_len_d       = len_word;
            phase_d         = PH_DEAD;
            res.lost_sync   = 1'b1;
            res.stream_dead = 1'b1;
          end else begin
            cur_len_d = len_word;
            id_d      = 16'd0;
            phase_d   = PH_BODY;
          end
        end
        PH_BODY: begin
          res.in_message     = 1'b1;
          res.message_length = cur_len_q;
          if (count_q == 16'd0) begin
            res.first_of_message = 1'b1;
            id_next              = {beat_i.data_byte, 8'h00};
          end else if (count_q == 16'd1) begin
            id_next = id_q | {8'h00, beat_i.data_byte};
          end
          id_d    = id_next;
          count_d = count_inc;
          if (count_inc >= cur_len_q) begin
            res.last_of_message = 1'b1;
            res.message_id      = id_next;
            cur_len_d           = LenIdle;
            count_d             = 16'd0;
            phase_d             = PH_LEN_HI;
          end
        end
        PH_DEAD: begin
          res.stream_dead = 1'b1;
        end
        default: begin
          phase_d = PH_LEN_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN_HI;
      len_hi_q  <= 8'd0;
      cur_len_q <= LenIdle;
      count_q   <= 16'd0;
      id_q      <= 16'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      len_hi_q  <= len_hi_d;
      cur_len_q <= cur_len_d;
      count_q   <= count_d;
      id_q      <= id_d;
    end
  end

  assign res_o = res;

endmodule

[src/dns_tcp_length_prefix_deframer_unit.sv]
// Top level: length-prefix deframer with input stage, framing logic and result register.
`timescale 1ns / 1ps
// Deframes a DNS-over-TCP byte stream: each message carries a two-byte big-endian
// length prefix, which is consumed and echoed without marks. A zero prefix is skipped;
// a nonzero prefix below min_message_length (APB register at byte address 0, reset 12)
// flags lost_sync and keeps the stream dead, echoing bytes with stream_dead set, until
// a restart beat (action = 1) arrives. Body bytes come out with in_message, first and
// last marks and the prefix length; the last body byte also carries the message ID
// built from the first two body bytes. Every input beat yields exactly one result beat.
// Throughput is one beat per clock while the output side is not stalled: the input
// register feeds the framing logic, whose result lands in the output register in the
// same cycle the framing state advances. An accepted beat waits in the input register
// until it advances into the output register. in_stall_o rises only when both the
// input and output registers hold beats and the output side is stalled.
module dns_tcp_length_prefix_deframer_unit import dtlpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic        in_valid_q, in_valid_d;
  in_beat_t    in_beat_q;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_beat_q;
  out_beat_t   res;
  logic [15:0] min_len;
  logic        advance, accept;

  dtlpd_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .min_len_o (min_len)
  );

  // Move the held input beat into the result register when the result slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  dtlpd_frame u_frame (
    .clk_i,
    .rst_ni,
    .step_i    (advance),
    .beat_i    (in_beat_q),
    .min_len_i (min_len),
    .res_o     (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the input register loads on acceptance, the result register on advance; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_beat_q <= in_data_i;
    end
    if (advance) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

endmodule

[src/dtlpd_checker.sv]
// Checker: port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
module dtlpd_checker import dtlpd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_beat_t           out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result slot is free");

  a_lost_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.lost_sync |-> out_data_o.stream_dead &&
      !out_data_o.in_message)
    else $error("lost_sync without stream_dead");

  a_marks_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.first_of_message || out_data_o.last_of_message)
      |-> out_data_o.in_message)
    else $error("message mark outside a body");

  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_message |-> out_data_o.message_length != 16'd0)
    else $error("body byte with zero length");

endmodule

bind dns_tcp_length_prefix_deframer_unit dtlpd_checker u_dtlpd_checker (.*);
